// File: hw/rtl/bse_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_pkg
// shared types and constants of the bucket sort engine
// ---------------------------------------------------------------------------
package bse_pkg;

   localparam int VAL_W       = 32;
   localparam int CNT_W       = 7;
   localparam int KCFG_W      = 7;
   localparam int MAX_BUCKETS = 64;

   // one loaded set, handed from the front to the back
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             sorted;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT,
      BK_PRD,
      BK_PEMIT
   } back_state_type;

endpackage

// File: hw/rtl/bse_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_req_if
// input channel: one sample per item
// ---------------------------------------------------------------------------
interface bse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_value;
   logic        is_final;

   modport source (output valid, output sample_value, output is_final, input ready);
   modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

// File: hw/rtl/bse_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_rsp_if
// result channel: one sorted value per item
// ---------------------------------------------------------------------------
interface bse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sorted_value;
   logic        end_of_run;

   modport source (output valid, output sorted_value, output end_of_run, input ready);
   modport sink   (input valid, input sorted_value, input end_of_run, output ready);
endinterface

// File: hw/rtl/bse_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_ram
// generic one write, one read ram with registered read data
// ---------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/bse_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_fifo
// two-entry job queue between the loader and the sorter
// ---------------------------------------------------------------------------
module bse_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bse_pkg::job_type    push_job,
   input  logic                pop,
   output bse_pkg::job_type    head_job,
   output logic                empty,
   output logic                full
);
   import bse_pkg::*;

   job_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   assign head_job = slot_ff[rptr_ff];
   assign empty    = (fill_ff == 2'd0);
   assign full     = (fill_ff == 2'd2);
endmodule

// File: hw/rtl/bse_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_front
// loader: stores samples, tracks min and max, queues a job on the final item
// ---------------------------------------------------------------------------
module bse_front #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   bse_req_if.sink                      req,
   input  logic [bse_pkg::KCFG_W-1:0]   bucket_count,
   input  logic                         fifo_full,
   input  logic                         job_done,
   output logic                         push,
   output bse_pkg::job_type             push_job,
   output logic                         wr_en,
   output logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
   output logic [31:0]                  wr_data
);
   import bse_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] min_ff, min_in, max_ff, max_in;
   logic             wait_ff, wait_in;
   logic             take, store;
   logic [KCFG_W-1:0] k_eff;

   assign req.ready = !wait_ff && !fifo_full;
   assign take      = req.valid && req.ready;
   assign store     = take && (count_ff < CNT_W'(MAX_ITEMS));
   assign k_eff     = (bucket_count > KCFG_W'(MAX_BUCKETS)) ? KCFG_W'(MAX_BUCKETS)
                                                             : bucket_count;

   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      wait_in  = wait_ff;
      if (store) begin
         count_in = count_ff + 1'b1;
         if (count_ff == '0) begin
            min_in = req.sample_value;
            max_in = req.sample_value;
         end else begin
            if ($signed(req.sample_value) < $signed(min_ff)) min_in = req.sample_value;
            if ($signed(req.sample_value) > $signed(max_ff)) max_in = req.sample_value;
         end
      end
      // the sorter sorts only when k and the range are both nonzero
      push_job.count  = count_in;
      push_job.sorted = (k_eff != '0) && (max_in != min_in);
      push            = take && req.is_final;
      if (push) begin
         count_in = '0;
         min_in   = '0;
         max_in   = '0;
         wait_in  = 1'b1;
      end
      if (job_done) begin
         wait_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         wait_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         wait_ff  <= wait_in;
      end
   end

   assign wr_en   = store;
   assign wr_addr = count_ff[$clog2(MAX_ITEMS)-1:0];
   assign wr_data = req.sample_value;
endmodule

// File: hw/rtl/bse_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bse_back
// sorter: selection passes over the store, or a plain replay in load order
// ---------------------------------------------------------------------------
module bse_back #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bse_pkg::job_type             head_job,
   input  logic                         fifo_empty,
   output logic                         pop,
   output logic                         job_done,
   output logic                         rd_en,
   output logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
   input  logic [31:0]                  rd_data,
   bse_rsp_if.source                    rsp
);
   import bse_pkg::*;

   back_state_type   state_ff, state_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] idx_ff, idx_in, sent_ff, sent_in, cnt_ff, cnt_in;
   logic             rvld_ff, rvld_in, first_ff, first_in, have_ff, have_in;
   logic [VAL_W-1:0] prev_ff, prev_in, cand_ff, cand_in;
   logic             ovld_ff, ovld_in, olast_ff, olast_in;
   logic [VAL_W-1:0] oval_ff, oval_in;
   logic             free, issue, eligible;

   assign free     = !ovld_ff || rsp.ready;
   assign issue    = (state_ff == BK_SCAN) && (idx_ff < job_ff.count);
   assign eligible = first_ff || ($signed(rd_data) > $signed(prev_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) state_in = head_job.sorted ? BK_SCAN : BK_PRD;
         end
         BK_SCAN: begin
            if (!issue && !rvld_ff) state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (free && cnt_ff == CNT_W'(1)) begin
               state_in = (sent_ff + 1'b1 == job_ff.count) ? BK_IDLE : BK_SCAN;
            end
         end
         BK_PRD: state_in = BK_PEMIT;
         BK_PEMIT: begin
            if (free) state_in = (idx_ff + 1'b1 == job_ff.count) ? BK_IDLE : BK_PRD;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      job_in   = job_ff;
      idx_in   = idx_ff;
      sent_in  = sent_ff;
      cnt_in   = cnt_ff;
      rvld_in  = 1'b0;
      first_in = first_ff;
      have_in  = have_ff;
      prev_in  = prev_ff;
      cand_in  = cand_ff;
      ovld_in  = ovld_ff && !rsp.ready;
      oval_in  = oval_ff;
      olast_in = olast_ff;
      pop      = 1'b0;
      job_done = 1'b0;
      rd_en    = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               job_in   = head_job;
               idx_in   = '0;
               sent_in  = '0;
               first_in = 1'b1;
               have_in  = 1'b0;
            end
         end
         BK_SCAN: begin
            if (issue) begin
               rd_en   = 1'b1;
               rvld_in = 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
            // smallest value above the last one sent, with its multiplicity
            if (rvld_ff && eligible) begin
               if (!have_ff || $signed(rd_data) < $signed(cand_ff)) begin
                  cand_in = rd_data;
                  cnt_in  = CNT_W'(1);
                  have_in = 1'b1;
               end else if (rd_data == cand_ff) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         BK_EMIT: begin
            if (free) begin
               ovld_in  = 1'b1;
               oval_in  = cand_ff;
               olast_in = (sent_ff + 1'b1 == job_ff.count);
               sent_in  = sent_ff + 1'b1;
               cnt_in   = cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  prev_in  = cand_ff;
                  first_in = 1'b0;
                  have_in  = 1'b0;
                  idx_in   = '0;
                  job_done = olast_in;
               end
            end
         end
         BK_PRD: begin
            rd_en = 1'b1;
         end
         BK_PEMIT: begin
            if (free) begin
               ovld_in  = 1'b1;
               oval_in  = rd_data;
               olast_in = (idx_ff + 1'b1 == job_ff.count);
               idx_in   = idx_ff + 1'b1;
               sent_in  = sent_ff + 1'b1;
               job_done = olast_in;
            end
         end
         default: begin
            job_done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rvld_ff  <= 1'b0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvld_ff  <= rvld_in;
         ovld_ff  <= ovld_in;
      end
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      sent_ff  <= sent_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
      have_ff  <= have_in;
      prev_ff  <= prev_in;
      cand_ff  <= cand_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
   end

   assign rd_addr          = idx_ff[$clog2(MAX_ITEMS)-1:0];
   assign rsp.valid        = ovld_ff;
   assign rsp.sorted_value = oval_ff;
   assign rsp.end_of_run   = olast_ff;

`ifndef SYNTHESIS
   a_emit_has_cand: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_EMIT |-> have_ff && cnt_ff != '0)
      else $error("emit without a candidate");
   a_sent_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != BK_IDLE |-> sent_ff < job_ff.count)
      else $error("more values sent than loaded");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      job_done |=> ovld_ff && olast_ff && state_ff == BK_IDLE)
      else $error("run ended without a final item");
`endif
endmodule

// File: hw/rtl/bucket_sort_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bucket_sort_engine
// min/max gated selection sort of signed Q16.16 samples
// ---------------------------------------------------------------------------
//  channel  direction  payload                       handshake
//  req      in         sample_value[31:0], is_final  valid/ready
//  rsp      out        sorted_value[31:0], end_of_run valid/ready
//  csr      in         bucket_count[6:0]             csr_wr_en
//
// loading takes one item per cycle while req.ready is high; the final item
// hands the set to the sorter; sorted runs make one scan of the store ram
// per distinct value, and replayed runs read each item before handing it out
// no new set is taken until the previous run has been handed out
// reset is synchronous; bucket_count returns to 5
// ---------------------------------------------------------------------------
module bucket_sort_engine #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   bse_req_if.sink                    req,
   bse_rsp_if.source                  rsp,
   input  logic                       csr_wr_en,
   input  logic [bse_pkg::KCFG_W-1:0] csr_wr_data
);
   import bse_pkg::*;

   localparam int AW = $clog2(MAX_ITEMS);

   logic [KCFG_W-1:0] kcfg_ff, kcfg_in;
   job_type           push_job, head_job;
   logic              push, pop, empty, full, job_done;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [VAL_W-1:0]  wr_data, rd_data;

   assign kcfg_in = csr_wr_en ? csr_wr_data : kcfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kcfg_ff <= KCFG_W'(5);
      end else begin
         kcfg_ff <= kcfg_in;
      end
   end

   bse_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
      .clock, .reset, .req,
      .bucket_count(kcfg_ff),
      .fifo_full(full), .job_done,
      .push, .push_job,
      .wr_en, .wr_addr, .wr_data
   );

   bse_fifo u_fifo (
      .clock, .reset, .push, .push_job,
      .pop, .head_job, .empty, .full
   );

   bse_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data,
      .rd_en, .rd_addr, .rd_data
   );

   bse_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
      .clock, .reset, .head_job,
      .fifo_empty(empty), .pop, .job_done,
      .rd_en, .rd_addr, .rd_data, .rsp
   );
endmodule
